FILE: rtl/ott_pkg.sv
package ott_pkg;

  localparam int TAG_BITS   = 32;
  localparam int INDEX_BITS = 6;
  localparam int WORD_BITS  = 32;
  localparam int COUNT_BITS = 7;
  localparam int ACT_BITS   = 3;
  localparam int STAT_BITS  = 2;
  // wide enough for any cell position, fill level or index compare
  localparam int CMP_BITS   = 12;

  localparam logic [ACT_BITS-1:0] ACT_APPEND     = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_READ_IDX   = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_FIND_TAG   = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_REMOVE_IDX = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_REMOVE_TAG = 3'd4;
  localparam logic [ACT_BITS-1:0] ACT_CLEAR      = 3'd5;
  localparam logic [ACT_BITS-1:0] ACT_COUNT      = 3'd6;

  localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_BAD_TAG   = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic capture;   // register the per-cell hit for a new item
    logic by_index;  // hit on position rather than tag
    logic match_en;  // tag compare allowed (key nonzero)
    logic append;    // write the new entry at the fill position
    logic shift;     // cells at or above pos take their upper neighbour
  } ott_ctl_t;

endpackage

FILE: rtl/ordered_tagged_table_top.sv
// Ordered tag table: up to CAPACITY entries held in a row of cells, each
// with a nonzero unique tag and a data word, kept dense in append order.
// An item is taken when the block is idle. In the cycle of acceptance
// every cell compares its tag (or its position) with the item in parallel
// and registers its hit; the one-hot hits are then merged into the result,
// and append writes the new entry on the edge that registers the result.
// Read, find, append, clear and count go through the LOOK state; a removal
// also goes through APPLY, the one-step shift of every cell above the
// removed entry towards the bottom of the row. The result sits in an
// output register and may wait there while the next item is accepted; an
// item that finishes while an earlier result is still untaken holds until
// the output register frees. No clearing pass is needed after reset.
module ordered_tagged_table_top
  import ott_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int DATA_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACT_BITS-1:0]   action,
  input  logic [TAG_BITS-1:0]   tag,
  input  logic [INDEX_BITS-1:0] index,
  input  logic [WORD_BITS-1:0]  data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STAT_BITS-1:0]  status,
  output logic [INDEX_BITS-1:0] found_index,
  output logic [TAG_BITS-1:0]   found_tag,
  output logic [WORD_BITS-1:0]  found_data,
  output logic [COUNT_BITS-1:0] count
);

  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [ACT_BITS-1:0]  act_r;
  logic [TAG_BITS-1:0]  key_r;
  logic [DATA_BITS-1:0] word_r;
  logic [CNT_BITS-1:0]  fill;
  logic [CNT_BITS-1:0]  fill_next;
  logic [IDX_BITS-1:0]  pos;
  logic                 do_shift;

  ott_ctl_t             ctl;
  logic [TAG_BITS-1:0]  cell_key;
  logic [CAPACITY-1:0]  hit_vec;
  logic [TAG_BITS-1:0]  cell_tag  [CAPACITY];
  logic [DATA_BITS-1:0] cell_word [CAPACITY];

  logic                 any_hit;
  logic [IDX_BITS-1:0]  hit_pos;
  logic [TAG_BITS-1:0]  hit_tag;
  logic [DATA_BITS-1:0] hit_word;

  logic                 accept;
  logic                 commit;
  logic [STAT_BITS-1:0] res_status;
  logic [IDX_BITS-1:0]  res_index;
  logic [TAG_BITS-1:0]  res_tag;
  logic [DATA_BITS-1:0] res_word;
  logic                 res_shift;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_LOOK) && (!out_valid || out_ready);
  assign cell_key = (state == S_IDLE) ? tag : key_r;

  // merge one-hot hits
  always_comb begin
    any_hit  = 1'b0;
    hit_pos  = '0;
    hit_tag  = '0;
    hit_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_hit  = any_hit | hit_vec[i];
      hit_pos  = hit_pos | (hit_vec[i] ? IDX_BITS'(i) : '0);
      hit_tag  = hit_tag | (hit_vec[i] ? cell_tag[i] : '0);
      hit_word = hit_word | (hit_vec[i] ? cell_word[i] : '0);
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_index  = '0;
    res_tag    = '0;
    res_word   = '0;
    res_shift  = 1'b0;
    fill_next  = fill;
    case (act_r)
      ACT_APPEND: begin
        if (key_r == '0 || any_hit) begin
          res_status = ST_BAD_TAG;
        end else if (fill == FULL) begin
          res_status = ST_FULL;
        end else begin
          res_index = IDX_BITS'(fill);
          res_tag   = key_r;
          res_word  = word_r;
          fill_next = fill + 1'b1;
        end
      end
      ACT_READ_IDX, ACT_FIND_TAG, ACT_REMOVE_IDX, ACT_REMOVE_TAG: begin
        if (any_hit) begin
          res_index = hit_pos;
          res_tag   = hit_tag;
          res_word  = hit_word;
          if (act_r == ACT_REMOVE_IDX || act_r == ACT_REMOVE_TAG) begin
            res_shift = 1'b1;
            fill_next = fill - 1'b1;
          end
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_CLEAR: fill_next = '0;
      ACT_COUNT: ;
      default:   res_status = ST_NOT_FOUND;
    endcase
  end

  always_comb begin
    ctl.capture  = accept;
    ctl.by_index = (action == ACT_READ_IDX) || (action == ACT_REMOVE_IDX);
    ctl.match_en = (tag != '0);
    ctl.append   = commit && (act_r == ACT_APPEND) && (res_status == ST_OK);
    ctl.shift    = (state == S_APPLY) && do_shift;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_LOOK;
      S_LOOK:  if (commit) state_next = res_shift ? S_APPLY : S_IDLE;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
      do_shift  <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
        do_shift  <= res_shift;
      end else begin
        if (out_valid && out_ready) begin
          out_valid <= 1'b0;
        end
        if (state == S_APPLY) begin
          do_shift <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= action;
      key_r  <= tag;
      word_r <= DATA_BITS'(data);
    end
    if (commit) begin
      pos         <= hit_pos;
      status      <= res_status;
      found_index <= INDEX_BITS'(res_index);
      found_tag   <= res_tag;
      found_data  <= WORD_BITS'(res_word);
      count       <= COUNT_BITS'(fill_next);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [TAG_BITS-1:0]  up_tag;
    logic [DATA_BITS-1:0] up_word;
    if (g == CAPACITY - 1) begin : g_last
      assign up_tag  = cell_tag[g];
      assign up_word = cell_word[g];
    end else begin : g_mid
      assign up_tag  = cell_tag[g+1];
      assign up_word = cell_word[g+1];
    end

    ott_cell #(
      .POS       (g),
      .DATA_BITS (DATA_BITS),
      .CNT_BITS  (CNT_BITS),
      .IDX_BITS  (IDX_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .fill     (fill),
      .pos      (pos),
      .key      (cell_key),
      .index    (index),
      .new_word (word_r),
      .up_tag   (up_tag),
      .up_word  (up_word),
      .hit      (hit_vec[g]),
      .tag      (cell_tag[g]),
      .word     (cell_word[g])
    );
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill level beyond capacity");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> $onehot0(hit_vec))
    else $error("more than one cell hit");

  a_shift_after_remove: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> ($past(state) == S_LOOK) && do_shift)
    else $error("shift without a removal");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (commit && act_r == ACT_CLEAR) |=> (fill == '0) && (count == '0))
    else $error("clear left entries");

endmodule

FILE: rtl/ott_cell.sv
module ott_cell
  import ott_pkg::*;
#(
  parameter int POS       = 0,
  parameter int DATA_BITS = 32,
  parameter int CNT_BITS  = 7,
  parameter int IDX_BITS  = 6
) (
  input  logic                  clk,
  input  ott_ctl_t              ctl,
  input  logic [CNT_BITS-1:0]   fill,
  input  logic [IDX_BITS-1:0]   pos,
  input  logic [TAG_BITS-1:0]   key,
  input  logic [INDEX_BITS-1:0] index,
  input  logic [DATA_BITS-1:0]  new_word,
  input  logic [TAG_BITS-1:0]   up_tag,
  input  logic [DATA_BITS-1:0]  up_word,
  output logic                  hit,
  output logic [TAG_BITS-1:0]   tag,
  output logic [DATA_BITS-1:0]  word
);

  localparam logic [CMP_BITS-1:0] MY_POS = CMP_BITS'(POS);

  logic live;
  logic at_end;
  logic above;
  logic idx_eq;

  assign live   = MY_POS < CMP_BITS'(fill);
  assign at_end = MY_POS == CMP_BITS'(fill);
  assign above  = MY_POS >= CMP_BITS'(pos);
  assign idx_eq = MY_POS == CMP_BITS'(index);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit <= live && (ctl.by_index ? idx_eq : (ctl.match_en && (tag == key)));
    end
    if (ctl.append && at_end) begin
      tag  <= key;
      word <= new_word;
    end else if (ctl.shift && above) begin
      // close the gap left by a removal
      tag  <= up_tag;
      word <= up_word;
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench
  import ott_pkg::*;
();

  localparam int CAPACITY   = 64;
  localparam int DATA_BITS  = 32;
  localparam int IDLE_LIMIT = 500;
  localparam int REPORT_MAX = 10;
  localparam logic [ACT_BITS-1:0] ACT_UNUSED = 3'd7;

  typedef struct {
    logic [ACT_BITS-1:0]   act;
    logic [TAG_BITS-1:0]   key;
    logic [INDEX_BITS-1:0] pos;
    logic [WORD_BITS-1:0]  word;
  } table_cmd_t;

  typedef struct {
    logic [STAT_BITS-1:0]  st;
    logic [INDEX_BITS-1:0] idx;
    logic [TAG_BITS-1:0]   tg;
    logic [WORD_BITS-1:0]  wd;
    logic [COUNT_BITS-1:0] fill;
  } table_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ACT_BITS-1:0]   action = '0;
  logic [TAG_BITS-1:0]   tag = '0;
  logic [INDEX_BITS-1:0] index = '0;
  logic [WORD_BITS-1:0]  data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STAT_BITS-1:0]  status;
  logic [INDEX_BITS-1:0] found_index;
  logic [TAG_BITS-1:0]   found_tag;
  logic [WORD_BITS-1:0]  found_data;
  logic [COUNT_BITS-1:0] count;

  ordered_tagged_table_top #(
    .CAPACITY (CAPACITY),
    .DATA_BITS(DATA_BITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .tag        (tag),
    .index      (index),
    .data       (data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found_index(found_index),
    .found_tag  (found_tag),
    .found_data (found_data),
    .count      (count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the table contents
  logic [TAG_BITS-1:0]  tbl_tags  [CAPACITY];
  logic [WORD_BITS-1:0] tbl_words [CAPACITY];
  int tbl_fill = 0;

  table_reply_t due_replies [$];

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold = 0;
  int idle_cycles = 0;
  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_full = 0;
  int peak_fill = 0;
  int act_seen [8];

  function automatic int tag_position(logic [TAG_BITS-1:0] key);
    int i;
    if (key == '0) return -1;
    for (i = 0; i < tbl_fill; i++)
      if (tbl_tags[i] == key) return i;
    return -1;
  endfunction

  function automatic table_reply_t apply_to_table(table_cmd_t c);
    table_reply_t r;
    int hit_pos;
    int i;
    r.st = ST_OK;
    r.idx = '0;
    r.tg = '0;
    r.wd = '0;
    hit_pos = -1;
    case (c.act)
      ACT_APPEND: begin
        if (c.key == '0 || tag_position(c.key) >= 0) begin
          r.st = ST_BAD_TAG;
        end else if (tbl_fill >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          tbl_tags[tbl_fill] = c.key;
          tbl_words[tbl_fill] = c.word;
          r.idx = INDEX_BITS'(tbl_fill);
          r.tg = c.key;
          r.wd = c.word;
          tbl_fill++;
        end
      end
      ACT_READ_IDX, ACT_REMOVE_IDX: begin
        if (int'(c.pos) < tbl_fill) hit_pos = int'(c.pos);
        else r.st = ST_NOT_FOUND;
      end
      ACT_FIND_TAG, ACT_REMOVE_TAG: begin
        hit_pos = tag_position(c.key);
        if (hit_pos < 0) r.st = ST_NOT_FOUND;
      end
      ACT_CLEAR: tbl_fill = 0;
      ACT_COUNT: begin
      end
      default: r.st = ST_NOT_FOUND;
    endcase
    if (hit_pos >= 0) begin
      r.idx = INDEX_BITS'(hit_pos);
      r.tg = tbl_tags[hit_pos];
      r.wd = tbl_words[hit_pos];
      if (c.act == ACT_REMOVE_IDX || c.act == ACT_REMOVE_TAG) begin
        // close the gap: later entries move down one place
        for (i = hit_pos; i + 1 < tbl_fill; i++) begin
          tbl_tags[i] = tbl_tags[i + 1];
          tbl_words[i] = tbl_words[i + 1];
        end
        tbl_fill--;
      end
    end
    r.fill = COUNT_BITS'(tbl_fill);
    return r;
  endfunction

  function automatic table_cmd_t make_cmd(logic [ACT_BITS-1:0] a, logic [TAG_BITS-1:0] k,
                                          logic [INDEX_BITS-1:0] p, logic [WORD_BITS-1:0] w);
    table_cmd_t c;
    c.act = a;
    c.key = k;
    c.pos = p;
    c.word = w;
    return c;
  endfunction

  // A live tag with chance live_pct percent, sometimes a small one (zero included), else anything
  function automatic logic [TAG_BITS-1:0] pick_tag(int live_pct);
    int r;
    r = $urandom_range(99);
    if (tbl_fill > 0 && r < live_pct) return tbl_tags[$urandom_range(tbl_fill - 1)];
    if (r < live_pct + 10) return $urandom_range(8);
    return $urandom();
  endfunction

  function automatic logic [INDEX_BITS-1:0] pick_index();
    if (tbl_fill > 0 && $urandom_range(99) < 70)
      return INDEX_BITS'($urandom_range(tbl_fill - 1));
    return INDEX_BITS'($urandom_range(63));
  endfunction

  function automatic table_cmd_t random_item(int app_pct, int rm_pct, bit clear_ok);
    table_cmd_t c;
    int r;
    r = $urandom_range(99);
    c.key = pick_tag(70);
    c.pos = pick_index();
    c.word = $urandom();
    if (r < app_pct) begin
      c.act = ACT_APPEND;
      c.key = pick_tag(8);
    end else if (r < app_pct + rm_pct) begin
      c.act = $urandom_range(1) ? ACT_REMOVE_IDX : ACT_REMOVE_TAG;
    end else if (r < 95) begin
      c.act = $urandom_range(1) ? ACT_READ_IDX : ACT_FIND_TAG;
    end else if (r < 97) begin
      c.act = clear_ok ? ACT_CLEAR : ACT_COUNT;
    end else if (r == 97) begin
      c.act = ACT_COUNT;
    end else begin
      c.act = ACT_UNUSED;
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic send_item(input table_cmd_t c);
    table_reply_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= c.act;
    tag <= c.key;
    index <= c.pos;
    data <= c.word;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    r = apply_to_table(c);
    due_replies.push_back(r);
    n_items++;
    act_seen[c.act]++;
    if (r.st == ST_FULL) n_full++;
    if (tbl_fill > peak_fill) peak_fill = tbl_fill;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= REPORT_MAX) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Result checker
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      n_results++;
      if (due_replies.size() == 0) begin
        note_error($sformatf("result %0d arrived with nothing outstanding", n_results));
      end else begin
        want = due_replies.pop_front();
        if (status !== want.st || found_index !== want.idx || found_tag !== want.tg ||
            found_data !== want.wd || count !== want.fill)
          note_error($sformatf({"result %0d: expected st=%0d idx=%0d tag=%h data=%h cnt=%0d,",
                                " got st=%0d idx=%0d tag=%h data=%h cnt=%0d"},
                               n_results, want.st, want.idx, want.tg, want.wd, want.fill,
                               status, found_index, found_tag, found_data, count));
      end
    end
  end

  // Receiver: bursts of ready, short stalls and the odd long one
  always @(posedge clk) begin
    int r;
    if (rx_hold > 0) begin
      rx_hold--;
    end else if (rx_steady) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(99);
      if (r < 60) begin
        out_ready <= 1'b1;
        rx_hold = $urandom_range(7);
      end else if (r < 92) begin
        out_ready <= 1'b0;
        rx_hold = $urandom_range(2);
      end else begin
        out_ready <= 1'b0;
        rx_hold = $urandom_range(30, 8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, due_replies.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_item(make_cmd(ACT_COUNT, $urandom(), INDEX_BITS'($urandom()), $urandom()));
    send_item(make_cmd(ACT_READ_IDX, '0, '0, '0));
    send_item(make_cmd(ACT_APPEND, '0, 6'd63, '1));
    send_item(make_cmd(ACT_APPEND, '1, '0, '1));
    send_item(make_cmd(ACT_APPEND, 32'h1, 6'd63, '0));
    send_item(make_cmd(ACT_APPEND, '1, '0, 32'h5));
    send_item(make_cmd(ACT_APPEND, 32'h8000_0000, 6'd21, 32'hA5A5_5A5A));
    send_item(make_cmd(ACT_READ_IDX, $urandom(), 6'd2, $urandom()));
    send_item(make_cmd(ACT_READ_IDX, '1, 6'd63, '1));
    send_item(make_cmd(ACT_FIND_TAG, '1, 6'd63, '0));
    send_item(make_cmd(ACT_FIND_TAG, '0, '0, '1));
    send_item(make_cmd(ACT_FIND_TAG, 32'h2, '0, '0));
    send_item(make_cmd(ACT_REMOVE_IDX, '0, '0, '0));
    send_item(make_cmd(ACT_READ_IDX, '0, '0, '0));
    send_item(make_cmd(ACT_REMOVE_TAG, 32'h1234_5678, '0, '0));
    send_item(make_cmd(ACT_REMOVE_TAG, 32'h1, 6'd63, '1));
    send_item(make_cmd(ACT_REMOVE_IDX, $urandom(), 6'd5, $urandom()));
    send_item(make_cmd(ACT_UNUSED, '1, 6'd63, '1));
    send_item(make_cmd(ACT_CLEAR, '1, 6'd63, '1));
    send_item(make_cmd(ACT_FIND_TAG, 32'h8000_0000, '0, '0));
    send_item(make_cmd(ACT_COUNT, '0, '0, '0));
  endtask

  task automatic test_fill_to_capacity();
    int guard;
    guard = 0;
    while (tbl_fill < CAPACITY && guard < 300) begin
      send_item(random_item(75, 5, 1'b0));
      guard++;
    end
    // full table: a bad tag is reported ahead of the full condition
    send_item(make_cmd(ACT_APPEND, $urandom(), pick_index(), $urandom()));
    send_item(make_cmd(ACT_APPEND, pick_tag(100), pick_index(), $urandom()));
    send_item(make_cmd(ACT_APPEND, '0, pick_index(), $urandom()));
    send_item(make_cmd(ACT_READ_IDX, $urandom(), 6'd63, $urandom()));
    send_item(make_cmd(ACT_FIND_TAG, pick_tag(100), '0, '0));
    send_item(make_cmd(ACT_REMOVE_IDX, $urandom(), 6'd63, $urandom()));
    send_item(make_cmd(ACT_COUNT, $urandom(), INDEX_BITS'($urandom()), $urandom()));
  endtask

  task automatic test_full_churn();
    repeat (150) send_item(random_item(48, 40, 1'b0));
  endtask

  task automatic test_random_mix();
    // open with a stretch with no send gaps and the receiver held ready once its current hold ends
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (60) send_item(random_item(35, 25, 1'b1));
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (240) send_item(random_item(35, 25, 1'b1));
  endtask

  task automatic test_drain();
    int guard;
    guard = 0;
    while (tbl_fill > 0 && guard < 250) begin
      send_item(random_item(5, 70, 1'b0));
      guard++;
    end
    repeat (6) send_item(random_item(10, 40, 1'b0));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    hold_until_drained();
    test_fill_to_capacity();
    hold_until_drained();
    test_full_churn();
    test_random_mix();
    hold_until_drained();
    test_drain();
    hold_until_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d items: %0d append, %0d read, %0d find, %0d remove, %0d clear, %0d count,",
             n_items, act_seen[ACT_APPEND], act_seen[ACT_READ_IDX], act_seen[ACT_FIND_TAG],
             act_seen[ACT_REMOVE_IDX] + act_seen[ACT_REMOVE_TAG], act_seen[ACT_CLEAR],
             act_seen[ACT_COUNT]);
    $display("%0d unused; %0d results checked, peak fill %0d of %0d, %0d appends refused full",
             act_seen[ACT_UNUSED], n_results, peak_fill, CAPACITY, n_full);
    if (n_errors == 0 && due_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d results still outstanding", n_errors, due_replies.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ott_pkg.sv
rtl/ott_cell.sv
rtl/ordered_tagged_table_top.sv
test/testbench.sv
